### src/uart_dual_ring_buffer_engine_unit_macros.svh
// Assertion macros shared by the serial ring buffer engine RTL.
`ifndef UART_DUAL_RING_BUFFER_ENGINE_UNIT_MACROS_SVH
`define UART_DUAL_RING_BUFFER_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define URB_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define URB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define URB_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define URB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### src/uartrb_pkg.sv
// Package: types, constants and pointer helpers for the serial ring buffer engine.
`default_nettype none
package uartrb_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int SIZE_W     = 7;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_RX_SIZE     = 3'd0;
    localparam logic [2:0] REG_TX_SIZE     = 3'd1;
    localparam logic [2:0] REG_ECHO_ENABLE = 3'd2;
    localparam logic [2:0] REG_ESCAPE_CHAR = 3'd3;
    localparam logic [2:0] REG_RX_ENABLE   = 3'd4;

    // reset values
    localparam logic [SIZE_W-1:0] RX_SIZE_RST     = 7'd64;
    localparam logic [SIZE_W-1:0] TX_SIZE_RST     = 7'd64;
    localparam logic              ECHO_ENABLE_RST = 1'b0;
    localparam logic [7:0]        ESCAPE_CHAR_RST = 8'h0A; // newline
    localparam logic              RX_ENABLE_RST   = 1'b1;

    // request codes
    localparam logic [1:0] REQ_RX_BYTE = 2'd0;
    localparam logic [1:0] REQ_HOST_WR = 2'd1;
    localparam logic [1:0] REQ_HOST_RD = 2'd2;
    localparam logic [1:0] REQ_TX_DONE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_accepted;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       escape_hit;
        logic       overflow_seen;
    } out_beat_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rx_size;
        logic [SIZE_W-1:0] tx_size;
        logic              echo_enable;
        logic [7:0]        escape_char;
        logic              rx_enable;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic send;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // ring size clamped to 2..RING_DEPTH
    function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        int s;
        logic [CNT_W-1:0] r;
        s = int'(size);
        if (s < 2) begin
            r = CNT_W'(2);
        end else if (s > RING_DEPTH) begin
            r = CNT_W'(RING_DEPTH);
        end else begin
            r = CNT_W'(s);
        end
        return r;
    endfunction

    // step a ring pointer, wrapping at the clamped size
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [SIZE_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = {1'b0, p} + CNT_W'(1);
        return (n >= eff_size(size)) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/uartrb_regs.sv
// APB configuration register file.
`default_nettype none
module uartrb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [uartrb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [uartrb_pkg::DATA_W-1:0] pwdata,
    output logic      [uartrb_pkg::DATA_W-1:0] prdata,
    output logic                               pready,
    output uartrb_pkg::cfg_t                   cfg
);
    uartrb_pkg::cfg_t cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                uartrb_pkg::REG_RX_SIZE:     cfg_next.rx_size     = pwdata[6:0];
                uartrb_pkg::REG_TX_SIZE:     cfg_next.tx_size     = pwdata[6:0];
                uartrb_pkg::REG_ECHO_ENABLE: cfg_next.echo_enable = pwdata[0];
                uartrb_pkg::REG_ESCAPE_CHAR: cfg_next.escape_char = pwdata[7:0];
                uartrb_pkg::REG_RX_ENABLE:   cfg_next.rx_enable   = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            uartrb_pkg::REG_RX_SIZE:     prdata = {25'd0, cfg_reg.rx_size};
            uartrb_pkg::REG_TX_SIZE:     prdata = {25'd0, cfg_reg.tx_size};
            uartrb_pkg::REG_ECHO_ENABLE: prdata = {31'd0, cfg_reg.echo_enable};
            uartrb_pkg::REG_ESCAPE_CHAR: prdata = {24'd0, cfg_reg.escape_char};
            uartrb_pkg::REG_RX_ENABLE:   prdata = {31'd0, cfg_reg.rx_enable};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rx_size     <= uartrb_pkg::RX_SIZE_RST;
            cfg_reg.tx_size     <= uartrb_pkg::TX_SIZE_RST;
            cfg_reg.echo_enable <= uartrb_pkg::ECHO_ENABLE_RST;
            cfg_reg.escape_char <= uartrb_pkg::ESCAPE_CHAR_RST;
            cfg_reg.rx_enable   <= uartrb_pkg::RX_ENABLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### src/uartrb_ctrl.sv
// Sequencer: accept, execute, transmit-send and result-load steps.
`default_nettype none
`include "uart_dual_ring_buffer_engine_unit_macros.svh"
module uartrb_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  uartrb_pkg::stat_t stat,
    output uartrb_pkg::cmd_t  cmd
);
    uartrb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uartrb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            uartrb_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = uartrb_pkg::ST_EXEC;
                end
            end
            uartrb_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = uartrb_pkg::ST_SEND;
            end
            uartrb_pkg::ST_SEND: begin
                cmd.send   = 1'b1;
                state_next = uartrb_pkg::ST_LOAD;
            end
            uartrb_pkg::ST_LOAD: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = uartrb_pkg::ST_IDLE;
                end
            end
            default: state_next = uartrb_pkg::ST_IDLE;
        endcase
    end

    `URB_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == uartrb_pkg::ST_EXEC)
    `URB_ASSERT_NEXT(a_exec_send, aclk, aresetn, cmd.exec, cmd.send)

endmodule
`default_nettype wire

### src/uartrb_dp.sv
// Datapath: both rings, pointers, line state and the result register.
`default_nettype none
`include "uart_dual_ring_buffer_engine_unit_macros.svh"
module uartrb_dp (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  uartrb_pkg::cfg_t      cfg,
    input  uartrb_pkg::cmd_t      cmd,
    output uartrb_pkg::stat_t     stat,
    input  uartrb_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output uartrb_pkg::out_beat_t m_data
);
    localparam int PW = uartrb_pkg::PTR_W;

    logic [7:0] rx_mem [uartrb_pkg::RING_DEPTH];
    logic [7:0] tx_mem [uartrb_pkg::RING_DEPTH];

    logic [1:0]    req_reg;
    logic [7:0]    byte_reg;
    logic [PW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic          ovf_reg, ovf_next, busy_reg, busy_next;
    logic          rvalid_reg, rvalid_next, wacc_reg, wacc_next;
    logic          txv_reg, txv_next, esc_reg, esc_next, send_reg, send_next;
    logic [7:0]    rx_rdata_reg, tx_rdata_reg;
    logic          m_valid_reg, m_valid_next;
    uartrb_pkg::out_beat_t m_data_reg, m_data_next;

    logic          rx_we, tx_we, rx_re, tx_re, tx_full;
    logic [PW-1:0] rx_head_adv, rx_tail_adv, tx_head_adv, tx_tail_adv;

    assign rx_head_adv = uartrb_pkg::advance(rx_head_reg, cfg.rx_size);
    assign rx_tail_adv = uartrb_pkg::advance(rx_tail_reg, cfg.rx_size);
    assign tx_head_adv = uartrb_pkg::advance(tx_head_reg, cfg.tx_size);
    assign tx_tail_adv = uartrb_pkg::advance(tx_tail_reg, cfg.tx_size);
    // one slot kept free in the transmit ring
    assign tx_full     = (tx_head_adv == tx_tail_reg);

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    always_comb begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        ovf_next     = ovf_reg;
        busy_next    = busy_reg;
        rvalid_next  = rvalid_reg;
        wacc_next    = wacc_reg;
        txv_next     = txv_reg;
        esc_next     = esc_reg;
        send_next    = send_reg;
        rx_we = 1'b0;
        tx_we = 1'b0;
        rx_re = 1'b0;
        tx_re = 1'b0;

        if (cmd.exec) begin
            rvalid_next = 1'b0;
            wacc_next   = 1'b0;
            txv_next    = 1'b0;
            esc_next    = 1'b0;
            send_next   = 1'b0;
            case (req_reg)
                uartrb_pkg::REQ_RX_BYTE: begin
                    if (cfg.rx_enable) begin
                        rx_we        = 1'b1;
                        rx_head_next = rx_head_adv;
                        // full: drop the oldest byte
                        if (rx_head_adv == rx_tail_reg) begin
                            rx_tail_next = rx_tail_adv;
                            ovf_next     = 1'b1;
                        end
                        if (cfg.echo_enable) begin
                            if (!tx_full) begin
                                tx_we        = 1'b1;
                                tx_head_next = tx_head_adv;
                            end
                            send_next = !busy_reg;
                        end
                        esc_next = (byte_reg == cfg.escape_char);
                    end
                end
                uartrb_pkg::REQ_HOST_WR: begin
                    if (!tx_full) begin
                        tx_we        = 1'b1;
                        tx_head_next = tx_head_adv;
                        wacc_next    = 1'b1;
                    end
                    send_next = !busy_reg;
                end
                uartrb_pkg::REQ_HOST_RD: begin
                    if (rx_tail_reg != rx_head_reg) begin
                        rx_re        = 1'b1;
                        rvalid_next  = 1'b1;
                        rx_tail_next = rx_tail_adv;
                    end
                end
                uartrb_pkg::REQ_TX_DONE: send_next = 1'b1;
                default: ;
            endcase
        end

        if (cmd.send && send_reg) begin
            if (tx_head_reg != tx_tail_reg) begin
                tx_re        = 1'b1;
                txv_next     = 1'b1;
                tx_tail_next = tx_tail_adv;
                busy_next    = 1'b1;
            end else begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next               = 1'b1;
            m_data_next.read_data      = rvalid_reg ? rx_rdata_reg : 8'd0;
            m_data_next.read_valid     = rvalid_reg;
            m_data_next.write_accepted = wacc_reg;
            m_data_next.tx_byte        = txv_reg ? tx_rdata_reg : 8'd0;
            m_data_next.tx_valid       = txv_reg;
            m_data_next.escape_hit     = esc_reg;
            m_data_next.overflow_seen  = ovf_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            ovf_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // per-item flags and payload, rewritten every item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= s_data.req_type;
            byte_reg <= s_data.data_byte;
        end
        rvalid_reg <= rvalid_next;
        wacc_reg   <= wacc_next;
        txv_reg    <= txv_next;
        esc_reg    <= esc_next;
        send_reg   <= send_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_head_reg] <= byte_reg;
        end
        if (rx_re) begin
            rx_rdata_reg <= rx_mem[rx_tail_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_head_reg] <= byte_reg;
        end
        if (tx_re) begin
            tx_rdata_reg <= tx_mem[tx_tail_reg];
        end
    end

    `URB_ASSERT_NEXT(a_send_busy, aclk, aresetn, cmd.send && send_reg && (tx_head_reg != tx_tail_reg), busy_reg)
    `URB_ASSERT_IMPL(a_one_kind, aclk, aresetn, m_valid_reg, !(m_data_reg.read_valid && (m_data_reg.write_accepted || m_data_reg.escape_hit)))

endmodule
`default_nettype wire

### src/uart_dual_ring_buffer_engine_unit.sv
// Top level of the serial port receive/transmit ring buffer engine.
// The sequencer runs accept, execute, transmit-send and load steps, as each ring
// read has a registered port; the load step waits while the result register is
//   held. A new request is taken only after the load step of the one before.
// Reset (aresetn low, synchronous): ring pointers, overflow flag and line state
//   cleared, registers to defaults; ring storage is not cleared.
`default_nettype none
module uart_dual_ring_buffer_engine_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  uartrb_pkg::in_beat_t               s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output uartrb_pkg::out_beat_t              m_data,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [uartrb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [uartrb_pkg::DATA_W-1:0] pwdata,
    output logic      [uartrb_pkg::DATA_W-1:0] prdata,
    output logic                               pready
);
    uartrb_pkg::cfg_t  cfg;
    uartrb_pkg::cmd_t  cmd;
    uartrb_pkg::stat_t stat;

    // register file: ring sizes, echo, escape character, receive enable
    uartrb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one request beat in flight at a time; the result register
    // decouples the result channel, so a new beat is taken while one waits
    uartrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // rings, pointers, line-busy state, result register
    uartrb_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
